@@ rtl/tdpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO drain package
// Shared beat types, opcodes, result kinds and defaults for the packet FIFO.
// ----------------------------------------------------------------------------
package tdpf_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 16;
    localparam logic [4:0]  CAPACITY_RESET  = 5'd16;

    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] KIND_ACCEPTED = 3'd0;
    localparam logic [2:0] KIND_DROPPED  = 3'd1;
    localparam logic [2:0] KIND_SERVICED = 3'd2;
    localparam logic [2:0] KIND_TICK     = 3'd3;
    localparam logic [2:0] KIND_EMPTY    = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] packet_bytes;
        logic [15:0] packet_tag;
        logic [15:0] tick_budget;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [15:0] out_tag;
        logic [15:0] out_bytes;
        logic [31:0] out_delay;
        logic [31:0] out_time;
        logic [15:0] tick_served;
        logic [31:0] total_count;
        logic [47:0] total_bytes;
        logic [47:0] total_delay;
        logic [4:0]  occupancy_now;
        logic        last_of_run;
    } out_beat_t;

    typedef struct packed {
        logic [15:0] remaining;
        logic [15:0] size;
        logic [31:0] arrival;
        logic [15:0] label;
    } entry_t;

endpackage

@@ rtl/tail_drop_packet_fifo_drain_top.sv @@
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO drain
// Bounded packet queue with tail drop, served at one byte per time unit.
// ----------------------------------------------------------------------------
// A push, a pop on an empty queue and an unknown opcode are handled in the idle state.
// A pop of a queued packet uses the registered read of the entry memory, followed
// by the delay and the saturating total updates.
// A tick checks its budget, serves each whole head packet that fits, drains one in
// part when the budget runs short, then reports; one item is in work at a time.
// Reset clears all control state and sets capacity_reg to 16; the entry memory
// is not cleared, since only occupied entries are ever used.
module tail_drop_packet_fifo_drain_top
    import tdpf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data,
    input  logic      cfg_wr_en,
    input  logic [4:0] cfg_wr_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned EXT_W = CNT_W + 5;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SERVE_A,
        S_SERVE_B,
        S_TICK_CHECK,
        S_TICK_READ,
        S_TICK_DONE
    } state_t;

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t      state_reg, state_next;
    logic [4:0]  capacity_reg, capacity_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [31:0] clock_reg, clock_next;
    logic [31:0] count_reg, count_next;
    logic [47:0] bytes_sum_reg, bytes_sum_next;
    logic [47:0] delay_sum_reg, delay_sum_next;
    logic [31:0] delay_reg, delay_next;
    logic [15:0] budget_reg, budget_next;
    logic [15:0] served_reg, served_next;
    logic        tick_mode_reg, tick_mode_next;
    logic        out_valid_reg, out_valid_next;
    out_beat_t   out_data_reg, out_data_next;

    logic        out_free;
    logic        emit;
    out_beat_t   emit_data;
    logic        mem_we;
    logic [PTR_W-1:0] mem_waddr;
    entry_t      mem_wdata;
    logic [EXT_W-1:0] fill_ext;
    logic [EXT_W-1:0] fill_next_ext;
    logic [EXT_W-1:0] cap_ext;
    logic [EXT_W-1:0] cap_eff;
    logic [48:0] bytes_sum_wide;
    logic [48:0] delay_sum_wide;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign fill_ext      = EXT_W'(fill_reg);
    assign fill_next_ext = EXT_W'(fill_next);
    assign cap_ext       = EXT_W'(capacity_reg);
    assign cap_eff       = (cap_ext > DEPTH_EXT) ? DEPTH_EXT : cap_ext;

    assign bytes_sum_wide = {1'b0, bytes_sum_reg} + 49'(rd_data_reg.size);
    assign delay_sum_wide = {1'b0, delay_sum_reg} + 49'(delay_reg);

    always_comb
    begin
        state_next     = state_reg;
        capacity_next  = cfg_wr_en ? cfg_wr_data : capacity_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        clock_next     = clock_reg;
        count_next     = count_reg;
        bytes_sum_next = bytes_sum_reg;
        delay_sum_next = delay_sum_reg;
        delay_next     = delay_reg;
        budget_next    = budget_reg;
        served_next    = served_reg;
        tick_mode_next = tick_mode_reg;
        mem_we         = 1'b0;
        mem_waddr      = tail_reg;
        mem_wdata      = '0;
        emit           = 1'b0;
        emit_data      = '0;
        in_ready       = (state_reg == S_IDLE) && out_free;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (in_data.opcode)
                        OP_PUSH:
                        begin
                            emit                  = 1'b1;
                            emit_data.out_tag     = in_data.packet_tag;
                            emit_data.out_bytes   = in_data.packet_bytes;
                            emit_data.last_of_run = 1'b1;
                            if (fill_ext < cap_eff)
                            begin
                                mem_we              = 1'b1;
                                mem_waddr           = tail_reg;
                                mem_wdata.remaining = in_data.packet_bytes;
                                mem_wdata.size      = in_data.packet_bytes;
                                mem_wdata.arrival   = clock_reg;
                                mem_wdata.label     = in_data.packet_tag;
                                tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                                fill_next = fill_reg + 1'b1;
                                emit_data.result_kind = KIND_ACCEPTED;
                            end
                            else
                            begin
                                emit_data.result_kind = KIND_DROPPED;
                            end
                        end
                        OP_POP:
                        begin
                            if (fill_reg == '0)
                            begin
                                emit                  = 1'b1;
                                emit_data.result_kind = KIND_EMPTY;
                                emit_data.last_of_run = 1'b1;
                            end
                            else
                            begin
                                tick_mode_next = 1'b0;
                                state_next     = S_SERVE_A;
                            end
                        end
                        OP_TICK:
                        begin
                            budget_next    = in_data.tick_budget;
                            served_next    = '0;
                            tick_mode_next = 1'b1;
                            state_next     = S_TICK_CHECK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SERVE_A:
            begin
                clock_next = clock_reg + 32'(rd_data_reg.remaining);
                delay_next = clock_next - rd_data_reg.arrival;
                state_next = S_SERVE_B;
            end
            S_SERVE_B:
            begin
                if (out_free)
                begin
                    count_next = (count_reg == '1) ? count_reg : count_reg + 1'b1;
                    bytes_sum_next = bytes_sum_wide[48] ? '1 : bytes_sum_wide[47:0];
                    delay_sum_next = delay_sum_wide[48] ? '1 : delay_sum_wide[47:0];
                    head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    fill_next = fill_reg - 1'b1;
                    emit                  = 1'b1;
                    emit_data.result_kind = KIND_SERVICED;
                    emit_data.out_tag     = rd_data_reg.label;
                    emit_data.out_bytes   = rd_data_reg.size;
                    emit_data.out_delay   = delay_reg;
                    emit_data.last_of_run = !tick_mode_reg;
                    state_next = tick_mode_reg ? S_TICK_CHECK : S_IDLE;
                end
            end
            S_TICK_CHECK:
            begin
                if (budget_reg == '0)
                begin
                    state_next = S_TICK_DONE;
                end
                else if (fill_reg == '0)
                begin
                    clock_next  = clock_reg + 32'(budget_reg);
                    budget_next = '0;
                    state_next  = S_TICK_DONE;
                end
                else
                begin
                    state_next = S_TICK_READ;
                end
            end
            S_TICK_READ:
            begin
                if (rd_data_reg.remaining <= budget_reg)
                begin
                    served_next = served_reg + rd_data_reg.remaining;
                    budget_next = budget_reg - rd_data_reg.remaining;
                    state_next  = S_SERVE_A;
                end
                else
                begin
                    mem_we              = 1'b1;
                    mem_waddr           = head_reg;
                    mem_wdata           = rd_data_reg;
                    mem_wdata.remaining = rd_data_reg.remaining - budget_reg;
                    served_next = served_reg + budget_reg;
                    clock_next  = clock_reg + 32'(budget_reg);
                    budget_next = '0;
                    state_next  = S_TICK_DONE;
                end
            end
            S_TICK_DONE:
            begin
                if (out_free)
                begin
                    emit                  = 1'b1;
                    emit_data.result_kind = KIND_TICK;
                    emit_data.tick_served = served_reg;
                    emit_data.last_of_run = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        emit_data.out_time      = clock_next;
        emit_data.total_count   = count_next;
        emit_data.total_bytes   = bytes_sum_next;
        emit_data.total_delay   = delay_sum_next;
        emit_data.occupancy_now = fill_next_ext[4:0];

        out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_data_next  = emit ? emit_data : out_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAPACITY_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            clock_reg     <= '0;
            count_reg     <= '0;
            bytes_sum_reg <= '0;
            delay_sum_reg <= '0;
            delay_reg     <= '0;
            budget_reg    <= '0;
            served_reg    <= '0;
            tick_mode_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            clock_reg     <= clock_next;
            count_reg     <= count_next;
            bytes_sum_reg <= bytes_sum_next;
            delay_sum_reg <= delay_sum_next;
            delay_reg     <= delay_next;
            budget_reg    <= budget_next;
            served_reg    <= served_next;
            tick_mode_reg <= tick_mode_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

endmodule

@@ tb/sv/tail_drop_packet_fifo_drain_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tail-drop packet FIFO drain testbench
// Sends push, pop and tick beats through the valid/ready input in random
// bursts, stalls the result side on its own pattern, and predicts every result
// beat from a behavioral model of the queue and its byte-rate server. Each
// accepted result beat is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tail_drop_packet_fifo_drain_top_tb;
    import tdpf_pkg::*;

    localparam int unsigned DEPTH            = QUEUE_DEPTH_DEF;
    localparam int unsigned WATCHDOG_LIMIT   = 2000;
    localparam int unsigned LONG_HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES    = 10;
    localparam int unsigned DRAIN_CYCLES     = 80;
    localparam int unsigned PHASE_ITEMS      = 88;
    localparam logic [1:0]  OP_UNUSED        = 2'd3;

    class drain_scoreboard;
        logic [15:0] slot_remaining [DEPTH];
        logic [15:0] slot_size [DEPTH];
        logic [31:0] slot_arrival [DEPTH];
        logic [15:0] slot_tag [DEPTH];
        int unsigned head_slot;
        int unsigned tail_slot;
        logic [4:0]  fill;
        logic [31:0] clock_now;
        logic [31:0] served_total;
        logic [47:0] bytes_total;
        logic [47:0] delay_total;
        logic [4:0]  capacity;
        out_beat_t   expected_beats [$];
        int unsigned error_count;

        function new();
            head_slot    = 0;
            tail_slot    = 0;
            fill         = '0;
            clock_now    = '0;
            served_total = '0;
            bytes_total  = '0;
            delay_total  = '0;
            capacity     = CAPACITY_RESET;
            error_count  = 0;
        endfunction

        function void add_report(logic [2:0] kind, logic [15:0] tag, logic [15:0] bytes,
                                 logic [31:0] delay, logic [15:0] served, logic last);
            out_beat_t beat;
            beat.result_kind   = kind;
            beat.out_tag       = tag;
            beat.out_bytes     = bytes;
            beat.out_delay     = delay;
            beat.out_time      = clock_now;
            beat.tick_served   = served;
            beat.total_count   = served_total;
            beat.total_bytes   = bytes_total;
            beat.total_delay   = delay_total;
            beat.occupancy_now = fill;
            beat.last_of_run   = last;
            expected_beats.push_back(beat);
        endfunction

        function void serve_head(logic last);
            logic [31:0] delay;
            logic [48:0] sum;
            clock_now = clock_now + 32'(slot_remaining[head_slot]);
            delay = clock_now - slot_arrival[head_slot];
            if (served_total != '1)
                served_total = served_total + 32'd1;
            sum = {1'b0, bytes_total} + 49'(slot_size[head_slot]);
            bytes_total = sum[48] ? '1 : sum[47:0];
            sum = {1'b0, delay_total} + 49'(delay);
            delay_total = sum[48] ? '1 : sum[47:0];
            slot_remaining[head_slot] = '0;
            fill = fill - 5'd1;
            add_report(KIND_SERVICED, slot_tag[head_slot], slot_size[head_slot], delay, '0,
                       last);
            head_slot = (head_slot + 1) % DEPTH;
        endfunction

        function void note_input(in_beat_t item);
            logic [4:0]  limit;
            int unsigned budget;
            int unsigned served;
            int unsigned rem;
            case (item.opcode)
                OP_PUSH:
                begin
                    limit = (capacity > DEPTH) ? 5'(DEPTH) : capacity;
                    if (fill < limit)
                    begin
                        slot_remaining[tail_slot] = item.packet_bytes;
                        slot_size[tail_slot]      = item.packet_bytes;
                        slot_arrival[tail_slot]   = clock_now;
                        slot_tag[tail_slot]       = item.packet_tag;
                        tail_slot = (tail_slot + 1) % DEPTH;
                        fill = fill + 5'd1;
                        add_report(KIND_ACCEPTED, item.packet_tag, item.packet_bytes, '0, '0,
                                   1'b1);
                    end
                    else
                    begin
                        add_report(KIND_DROPPED, item.packet_tag, item.packet_bytes, '0, '0,
                                   1'b1);
                    end
                end
                OP_POP:
                begin
                    if (fill == 0)
                        add_report(KIND_EMPTY, '0, '0, '0, '0, 1'b1);
                    else
                        serve_head(1'b1);
                end
                OP_TICK:
                begin
                    budget = item.tick_budget;
                    served = 0;
                    while (budget > 0)
                    begin
                        if (fill == 0)
                        begin
                            clock_now = clock_now + 32'(budget);
                            budget = 0;
                        end
                        else
                        begin
                            rem = slot_remaining[head_slot];
                            if (rem <= budget)
                            begin
                                served = served + rem;
                                budget = budget - rem;
                                serve_head(1'b0);
                            end
                            else
                            begin
                                slot_remaining[head_slot] = 16'(rem - budget);
                                served = served + budget;
                                clock_now = clock_now + 32'(budget);
                                budget = 0;
                            end
                        end
                    end
                    add_report(KIND_TICK, '0, '0, '0, 16'(served), 1'b1);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                $error("%s expected %0h actual %0h", name, want, got);
                error_count++;
            end
        endfunction

        function void check_report(out_beat_t got);
            out_beat_t want;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected, kind %0d", got.result_kind);
                error_count++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("result_kind", 48'(want.result_kind), 48'(got.result_kind));
            compare_field("out_tag", 48'(want.out_tag), 48'(got.out_tag));
            compare_field("out_bytes", 48'(want.out_bytes), 48'(got.out_bytes));
            compare_field("out_delay", 48'(want.out_delay), 48'(got.out_delay));
            compare_field("out_time", 48'(want.out_time), 48'(got.out_time));
            compare_field("tick_served", 48'(want.tick_served), 48'(got.tick_served));
            compare_field("total_count", 48'(want.total_count), 48'(got.total_count));
            compare_field("total_bytes", want.total_bytes, got.total_bytes);
            compare_field("total_delay", want.total_delay, got.total_delay);
            compare_field("occupancy_now", 48'(want.occupancy_now), 48'(got.occupancy_now));
            compare_field("last_of_run", 48'(want.last_of_run), 48'(got.last_of_run));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_beat_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_beat_t  out_data;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;

    drain_scoreboard sb;
    int unsigned     burst_left;
    int unsigned     quiet_cycles;
    bit              steady_send;
    bit              long_hold_pending;

    tail_drop_packet_fifo_drain_top #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic in_beat_t make_beat(logic [1:0] op, logic [15:0] bytes,
                                           logic [15:0] tag, logic [15:0] budget);
        in_beat_t beat;
        beat.opcode       = op;
        beat.packet_bytes = bytes;
        beat.packet_tag   = tag;
        beat.tick_budget  = budget;
        return beat;
    endfunction

    function automatic in_beat_t random_item();
        int unsigned pick;
        logic [1:0]  op;
        logic [15:0] bytes;
        logic [15:0] budget;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            op = OP_PUSH;
        else if (pick < 65)
            op = OP_POP;
        else if (pick < 95)
            op = OP_TICK;
        else
            op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            bytes = 16'd0;
        else if (pick < 10)
            bytes = 16'hFFFF;
        else if (pick < 20)
            bytes = 16'($urandom_range(0, 65535));
        else
            bytes = 16'($urandom_range(1, 400));
        pick = $urandom_range(0, 99);
        if (pick < 5)
            budget = 16'd0;
        else if (pick < 12)
            budget = 16'hFFFF;
        else if (pick < 25)
            budget = 16'($urandom_range(0, 65535));
        else
            budget = 16'($urandom_range(1, 1500));
        return make_beat(op, bytes, 16'($urandom_range(0, 65535)), budget);
    endfunction

    task automatic offer_item(input in_beat_t item);
        int unsigned gap;
        if (!steady_send && burst_left == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 16);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [4:0] value);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.capacity = value;
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned done;
        in_beat_t    item;
        done = 0;
        while (done < count)
        begin
            item = random_item();
            offer_item(item);
            if (item.opcode != OP_UNUSED)
                done++;
        end
    endtask

    initial
    begin : receiver
        int unsigned stall_cycle;
        int unsigned stall_mode;
        stall_cycle = 0;
        stall_mode  = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                if (stall_cycle % 64 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= (stall_cycle % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 9) != 0);
                endcase
                stall_cycle++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_report(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tail_drop_packet_fifo_drain_top verification failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int unsigned idx;
        sb = new();
        burst_left        = 0;
        quiet_cycles      = 0;
        steady_send       = 1'b0;
        long_hold_pending = 1'b0;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_item(make_beat(OP_POP, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'd100));
        offer_item(make_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        offer_item(make_beat(OP_PUSH, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_PUSH, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        offer_item(make_beat(OP_PUSH, 16'd1, 16'h5A5A, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'd1));
        offer_item(make_beat(OP_POP, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'hFFFF));
        offer_item(make_beat(OP_POP, 16'd0, 16'd0, 16'd0));
        write_capacity(5'd0);
        offer_item(make_beat(OP_PUSH, 16'd77, 16'h1234, 16'd0));
        write_capacity(5'd2);
        offer_item(make_beat(OP_PUSH, 16'd3, 16'hA5A5, 16'd0));
        offer_item(make_beat(OP_PUSH, 16'd5, 16'h0F0F, 16'd0));
        offer_item(make_beat(OP_PUSH, 16'd9, 16'hF0F0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'hFFFF));

        write_capacity(5'd16);
        steady_send = 1'b1;
        for (idx = 0; idx < 5; idx++)
            offer_item(make_beat(OP_PUSH, 16'hFFFF, 16'(16'h0100 + idx), 16'd0));
        for (idx = 0; idx < 5; idx++)
            offer_item(make_beat(OP_POP, 16'd0, 16'd0, 16'd0));
        offer_item(make_beat(OP_TICK, 16'd0, 16'd0, 16'hFFFF));
        steady_send = 1'b0;

        run_random(PHASE_ITEMS);
        write_capacity(5'd31);
        long_hold_pending = 1'b1;
        run_random(PHASE_ITEMS);
        write_capacity(5'd5);
        run_random(PHASE_ITEMS);
        write_capacity(5'($urandom_range(0, 31)));
        run_random(PHASE_ITEMS);

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.expected_beats.size() != 0)
        begin
            $error("%0d result beats never arrived", sb.expected_beats.size());
            sb.error_count++;
        end
        if (sb.error_count == 0)
            $display("tail_drop_packet_fifo_drain_top verification clean");
        else
            $display("tail_drop_packet_fifo_drain_top verification failed");
        $finish;
    end
endmodule

@@ files.f @@
rtl/tdpf_pkg.sv
rtl/tail_drop_packet_fifo_drain_top.sv
tb/sv/tail_drop_packet_fifo_drain_top_tb.sv
